### hdl/rotation_matrix_to_quaternion_macros.svh
// Assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq check failed");
`define RMQ_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rmq check failed");
`else
`define RMQ_ASSERT_IMPL(lbl, ante, cons)
`define RMQ_ASSERT_NEVER(lbl, cond)
`endif
`endif

### hdl/rmq_pkg.sv
// Types, constants and step functions for the rotation matrix to quaternion block
`timescale 1ns / 1ps
package rmq_pkg;

    localparam int DW  = 16;          // element and component width
    localparam int FB  = 14;          // fraction bits
    localparam int TW  = DW + 2;      // trace, radicand and difference width
    localparam int SW  = DW + 1;      // square root result width
    localparam int XW  = 2 * SW;      // scaled radicand width
    localparam int RW  = SW + 3;      // square root remainder width
    localparam int NW  = DW + 1 + FB; // dividend and quotient width
    localparam int DRW = SW + 1;      // divider remainder width
    localparam int LATENCY = SW + NW + 3;

    localparam logic signed [TW-1:0] ONE = TW'(1) <<< FB;
    localparam logic signed [DW-1:0] QMAX = DW'((1 << (DW - 1)) - 1);
    localparam logic signed [DW-1:0] QMIN = DW'(1 << (DW - 1));

    typedef enum logic [1:0] {PICK_W, PICK_X, PICK_Y, PICK_Z} pick_t;

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [DW-1:0] quat_w;
        logic signed [DW-1:0] quat_x;
        logic signed [DW-1:0] quat_y;
        logic signed [DW-1:0] quat_z;
        logic                 status;
    } quat_t;

    typedef struct packed {
        logic                        valid;
        logic                        err;
        pick_t                       pick;
        logic [2:0][TW-1:0]          d;
        logic [XW-1:0]               x;
        logic [RW-1:0]               rem;
        logic [SW-1:0]               root;
    } sq_t;

    typedef struct packed {
        logic                        valid;
        logic                        err;
        pick_t                       pick;
        logic [SW-1:0]               s;
        logic [2:0]                  neg;
        logic [2:0][NW-1:0]          num;
        logic [2:0][DRW-1:0]         rem;
    } dv_t;

    // one root bit per call
    function automatic sq_t sq_step(input sq_t a);
        sq_t b;
        logic [RW-1:0] r;
        logic [RW-1:0] t;
        b = a;
        r = {a.rem[RW-3:0], a.x[XW-1:XW-2]};
        t = {1'b0, a.root, 2'b01};
        if (r >= t)
        begin
            b.rem  = r - t;
            b.root = {a.root[SW-2:0], 1'b1};
        end
        else
        begin
            b.rem  = r;
            b.root = {a.root[SW-2:0], 1'b0};
        end
        b.x = {a.x[XW-3:0], 2'b00};
        return b;
    endfunction

    // one quotient bit per lane per call; quotient shifts into num
    function automatic dv_t dv_step(input dv_t a);
        dv_t b;
        logic [DRW-1:0] r;
        b = a;
        for (int i = 0; i < 3; i++)
        begin
            r = {a.rem[i][DRW-2:0], a.num[i][NW-1]};
            if (r >= {1'b0, a.s})
            begin
                b.rem[i] = r - {1'b0, a.s};
                b.num[i] = {a.num[i][NW-2:0], 1'b1};
            end
            else
            begin
                b.rem[i] = r;
                b.num[i] = {a.num[i][NW-2:0], 1'b0};
            end
        end
        return b;
    endfunction

    function automatic logic signed [DW-1:0] sat_q(input logic neg, input logic [NW-1:0] q);
        logic signed [DW-1:0] v;
        if (!neg)
            v = (q > NW'(QMAX)) ? QMAX : DW'(q);
        else if (q > NW'(unsigned'(QMAX)) + NW'(1))
            v = QMIN;
        else
            v = DW'(-q);
        return v;
    endfunction

endpackage

### hdl/rotation_matrix_to_quaternion.sv
// Top level: pipelined rotation matrix to quaternion converter
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_macros.svh"
//
//  channel   ports                 transfer when
//  --------  --------------------  -------------------
//  matrix    start, busy, mat      start && !busy
//  quat      done, quat            done (one cycle)
//
//  One matrix enters per cycle; each result leaves after passing the stages below.
//  The depth is set by the bit-serial square root (17 stages, one root bit
//  each) followed by three parallel long dividers (31 stages, one quotient
//  bit each), plus a branch stage, a dividend stage and an output register.
//  busy stays low: the pipeline never stalls since the receiver takes every
//  result. Reset clears all valid bits; no clearing pass is needed.
//
module rotation_matrix_to_quaternion
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rmq_pkg::mat_t  mat,
    output logic           done,
    output rmq_pkg::quat_t quat
);
    import rmq_pkg::*;

    sq_t   sq_reg [0:SW];
    dv_t   dv_reg [0:NW];
    quat_t quat_reg;
    logic  done_reg;

    sq_t   sq_next;
    dv_t   dv_next;
    quat_t quat_next;

    logic signed [TW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [TW-1:0] tr, rad;

    // Branch stage: pick the Shepperd branch, form radicand and numerators.
    always_comb
    begin
        a00 = TW'(mat.m00); a01 = TW'(mat.m01); a02 = TW'(mat.m02);
        a10 = TW'(mat.m10); a11 = TW'(mat.m11); a12 = TW'(mat.m12);
        a20 = TW'(mat.m20); a21 = TW'(mat.m21); a22 = TW'(mat.m22);
        tr = a00 + a11 + a22;
        sq_next = '0;
        sq_next.valid = start && !busy;
        if (tr > 0)
        begin
            sq_next.pick = PICK_W;
            rad = tr + ONE;
            sq_next.d[0] = a12 - a21;
            sq_next.d[1] = a20 - a02;
            sq_next.d[2] = a01 - a10;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            sq_next.pick = PICK_X;
            rad = ONE + a00 - a11 - a22;
            sq_next.d[0] = a12 - a21;
            sq_next.d[1] = a10 + a01;
            sq_next.d[2] = a20 + a02;
        end
        else if (a11 > a22)
        begin
            sq_next.pick = PICK_Y;
            rad = ONE + a11 - a00 - a22;
            sq_next.d[0] = a20 - a02;
            sq_next.d[1] = a10 + a01;
            sq_next.d[2] = a21 + a12;
        end
        else
        begin
            sq_next.pick = PICK_Z;
            rad = ONE + a22 - a00 - a11;
            sq_next.d[0] = a01 - a10;
            sq_next.d[1] = a20 + a02;
            sq_next.d[2] = a21 + a12;
        end
        // a radicand that is not positive is flagged; feed a harmless 1 instead
        sq_next.err = !(rad > 0);
        if (sq_next.err)
            rad = TW'(1);
        sq_next.x = XW'({rad[SW-1:0], {(FB + 2){1'b0}}});
    end

    // Dividend stage: magnitude of each numerator scaled up, plus half the divisor.
    always_comb
    begin
        logic [SW-1:0] s;
        logic [TW-1:0] mag;
        s = sq_reg[SW].root;
        dv_next = '0;
        dv_next.valid = sq_reg[SW].valid;
        dv_next.err   = sq_reg[SW].err;
        dv_next.pick  = sq_reg[SW].pick;
        dv_next.s     = s;
        for (int i = 0; i < 3; i++)
        begin
            dv_next.neg[i] = sq_reg[SW].d[i][TW-1];
            mag = dv_next.neg[i] ? -sq_reg[SW].d[i] : sq_reg[SW].d[i];
            dv_next.num[i] = (NW'(mag) << FB) + NW'(s >> 1);
        end
    end

    // Output stage: saturate and place the picked quarter-S component.
    always_comb
    begin
        logic signed [DW-1:0] qs, o0, o1, o2;
        qs = sat_q(1'b0, (NW'(dv_reg[NW].s) + NW'(2)) >> 2);
        o0 = sat_q(dv_reg[NW].neg[0], dv_reg[NW].num[0]);
        o1 = sat_q(dv_reg[NW].neg[1], dv_reg[NW].num[1]);
        o2 = sat_q(dv_reg[NW].neg[2], dv_reg[NW].num[2]);
        quat_next = '0;
        case (dv_reg[NW].pick)
            PICK_X:
            begin
                quat_next.quat_w = o0; quat_next.quat_x = qs;
                quat_next.quat_y = o1; quat_next.quat_z = o2;
            end
            PICK_Y:
            begin
                quat_next.quat_w = o0; quat_next.quat_x = o1;
                quat_next.quat_y = qs; quat_next.quat_z = o2;
            end
            PICK_Z:
            begin
                quat_next.quat_w = o0; quat_next.quat_x = o1;
                quat_next.quat_y = o2; quat_next.quat_z = qs;
            end
            default:
            begin
                quat_next.quat_w = qs; quat_next.quat_x = o0;
                quat_next.quat_y = o1; quat_next.quat_z = o2;
            end
        endcase
        // drop the computed values on a bad radicand
        if (dv_reg[NW].err)
        begin
            quat_next = '0;
            quat_next.status = 1'b1;
        end
    end

    // Advance every stage each cycle; valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SW; i++)
                sq_reg[i] <= '0;
            for (int i = 0; i <= NW; i++)
                dv_reg[i] <= '0;
            quat_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            sq_reg[0] <= sq_next;
            for (int i = 0; i < SW; i++)
                sq_reg[i+1] <= sq_step(sq_reg[i]);
            dv_reg[0] <= dv_next;
            for (int i = 0; i < NW; i++)
                dv_reg[i+1] <= dv_step(dv_reg[i]);
            quat_reg <= quat_next;
            done_reg <= dv_reg[NW].valid;
        end
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign quat = quat_reg;

    // the four components sit above the status bit
    `RMQ_ASSERT_NEVER(a_never_busy, busy)
    `RMQ_ASSERT_IMPL(a_err_zero, done && quat.status, quat[4*DW:1] == '0)
    `RMQ_ASSERT_IMPL(a_latency, done, $past(start && !busy, LATENCY))

endmodule
